// ===== src/ftlb_pkg.sv =====
// Shared types and constants for the fully associative translation buffer.
// Used by ftlb_cell and fifo_replacement_tlb; depends on nothing else.
package ftlb_pkg;

	// Default number of entries in the buffer.
	localparam int FTLB_ENTRIES = 16;

	// Number of cells that the match chain crosses in one clock cycle.
	localparam int FTLB_GROUP = 8;

	// Width of the page and frame fields, and of the reported fill level.
	localparam int FTLB_FIELD_W = 16;
	localparam int FTLB_FILL_W  = 5;

	// Operation codes carried in tuser.
	localparam logic FTLB_OP_LOOKUP = 1'b0;
	localparam logic FTLB_OP_INSERT = 1'b1;

	// One stored translation.
	typedef struct packed {
		logic [FTLB_FIELD_W-1:0] page;
		logic [FTLB_FIELD_W-1:0] frame;
	} ftlb_pair_t;

	// Match result handed from cell to cell, oldest entry first.
	typedef struct packed {
		logic                    found;
		logic [FTLB_FIELD_W-1:0] frame;
	} ftlb_carry_t;

endpackage

// ===== src/ftlb_cell.sv =====
// One entry of the translation buffer: holds a page/frame pair and passes
// the oldest-match result on to the next younger cell. Depends on ftlb_pkg.
module ftlb_cell (
	input  logic                                clk,
	input  logic                                valid,
	input  logic                                shift_en,
	input  logic                                load_en,
	input  ftlb_pkg::ftlb_pair_t                next_pair,
	input  ftlb_pkg::ftlb_pair_t                new_pair,
	input  logic [ftlb_pkg::FTLB_FIELD_W-1:0]   key,
	input  ftlb_pkg::ftlb_carry_t               carry_in,
	output ftlb_pkg::ftlb_carry_t               carry_out,
	output ftlb_pkg::ftlb_pair_t                pair
);
	import ftlb_pkg::*;

	ftlb_pair_t pair_q;

	// Storage: a new pair is written here, or the younger neighbor's pair moves in.
	always_ff @(posedge clk) begin
		if (load_en) begin
			pair_q <= new_pair;
		end else if (shift_en) begin
			pair_q <= next_pair;
		end
	end

	assign pair = pair_q;

	// An older match wins; otherwise this cell answers if it holds the page.
	always_comb begin
		if (carry_in.found) begin
			carry_out = carry_in;
		end else if (valid && (pair_q.page == key)) begin
			carry_out.found = 1'b1;
			carry_out.frame = pair_q.frame;
		end else begin
			carry_out = '0;
		end
	end

endmodule

// ===== src/fifo_replacement_tlb.sv =====
// Fully associative translation buffer with first-in first-out replacement.
// Top level; instantiates ftlb_cell and depends on ftlb_pkg.
//
// The buffer is a row of ENTRIES cells ordered by age, the oldest in cell 0.
// An insert writes the first free cell, or, when the buffer is full, shifts
// every pair one cell toward the old end, drops the oldest and writes the
// new pair into the youngest cell. A lookup hands a match result down the
// row from the oldest cell, crossing eight cells per clock with a register
// between each group of eight, so the oldest matching entry answers.
// One item is worked on at a time: the input is held until it finishes,
// a lookup only once its result has passed every register of the match
// chain. A finished result waits in the output register while the next
// transfer is accepted. The store needs no clearing after reset: only
// cells below the fill count take part in a lookup.
module fifo_replacement_tlb #(
	parameter int ENTRIES = ftlb_pkg::FTLB_ENTRIES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [15:0] page_number, [31:16] frame_address
	input  logic [31:0] s_axis_tdata,
	// [0] op
	input  logic [0:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [0] hit, [16:1] frame_out, [17] evicted, [33:18] evicted_page,
	// [49:34] evicted_frame, [54:50] fill_level, [55] zero
	output logic [55:0] m_axis_tdata
);
	import ftlb_pkg::*;

	localparam int CW      = $clog2(ENTRIES + 1);
	localparam int NGROUPS = (ENTRIES + FTLB_GROUP - 1) / FTLB_GROUP;
	localparam int SW      = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;

	// Item being worked on.
	logic                    busy_q;
	logic                    op_q;
	ftlb_pair_t              item_q;
	logic [SW-1:0]           scan_q;

	// Occupancy.
	logic [CW-1:0]           count_q;

	// Output register.
	logic                    out_valid_q;
	logic                    hit_q;
	logic [FTLB_FIELD_W-1:0] frame_out_q;
	logic                    evicted_q;
	ftlb_pair_t              evicted_pair_q;
	logic [FTLB_FILL_W-1:0]  fill_q;

	// Row of cells.
	ftlb_pair_t              pairs     [ENTRIES];
	ftlb_carry_t             carry_out [ENTRIES];
	ftlb_carry_t             carry_in  [ENTRIES];

	logic                    full;
	logic                    finish;
	logic                    insert_do;
	logic [CW-1:0]           count_next;
	logic [CW+FTLB_FILL_W-1:0] fill_wide;

	assign full       = (count_q == CW'(ENTRIES));
	assign finish     = busy_q && (!out_valid_q || m_axis_tready) &&
	                    ((op_q == FTLB_OP_INSERT) || (scan_q == SW'(NGROUPS - 1)));
	assign insert_do  = finish && (op_q == FTLB_OP_INSERT);
	assign count_next = full ? count_q : count_q + CW'(1);
	assign fill_wide  = {{FTLB_FILL_W{1'b0}}, count_next};

	assign s_axis_tready = !busy_q;

	// Cells, with a register on the match chain after every group of eight.
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		logic load_en;
		logic shift_en;

		if (i == 0) begin : g_first
			assign carry_in[i] = '0;
		end else if ((i % FTLB_GROUP) == 0) begin : g_break
			ftlb_carry_t carry_s1;

			always_ff @(posedge clk) begin
				carry_s1 <= carry_out[i-1];
			end

			assign carry_in[i] = carry_s1;
		end else begin : g_link
			assign carry_in[i] = carry_out[i-1];
		end

		assign load_en  = insert_do &&
		                  (full ? (i == ENTRIES - 1) : (count_q == CW'(i)));
		assign shift_en = insert_do && full;

		ftlb_cell u_cell (
			.clk       (clk),
			.valid     (CW'(i) < count_q),
			.shift_en  (shift_en),
			.load_en   (load_en),
			.next_pair ((i == ENTRIES - 1) ? item_q : pairs[(i + 1) % ENTRIES]),
			.new_pair  (item_q),
			.key       (item_q.page),
			.carry_in  (carry_in[i]),
			.carry_out (carry_out[i]),
			.pair      (pairs[i])
		);
	end

	// Control: take a transfer, walk the match chain, count entries.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			scan_q  <= '0;
			count_q <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				busy_q <= 1'b1;
				scan_q <= '0;
			end else if (finish) begin
				busy_q <= 1'b0;
			end else if (busy_q && (scan_q != SW'(NGROUPS - 1))) begin
				scan_q <= scan_q + SW'(1);
			end
			if (insert_do) begin
				count_q <= count_next;
			end
		end
	end

	// Item payload captured on an input transfer.
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_q         <= s_axis_tuser[0];
			item_q.page  <= s_axis_tdata[15:0];
			item_q.frame <= s_axis_tdata[31:16];
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload: lookup answer or eviction report, and the new fill level.
	always_ff @(posedge clk) begin
		if (finish) begin
			if (op_q == FTLB_OP_INSERT) begin
				hit_q          <= 1'b0;
				frame_out_q    <= '0;
				evicted_q      <= full;
				evicted_pair_q <= full ? pairs[0] : '0;
				fill_q         <= fill_wide[FTLB_FILL_W-1:0];
			end else begin
				hit_q          <= carry_out[ENTRIES-1].found;
				frame_out_q    <= carry_out[ENTRIES-1].frame;
				evicted_q      <= 1'b0;
				evicted_pair_q <= '0;
				fill_q         <= fill_wide[FTLB_FILL_W-1:0] - FTLB_FILL_W'(!full);
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, fill_q, evicted_pair_q.frame, evicted_pair_q.page,
	                        evicted_q, frame_out_q, hit_q};

endmodule
